@@ rtl/core/cid_pkg.sv @@
// ----------------------------------------------------------------------------
// cid_pkg - card id table shared definitions
// Table geometry, opcodes, status codes and the structs between sequencer
// and store.
// ----------------------------------------------------------------------------
package cid_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // opcodes; code three is unused and acts as a no-op
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } cid_status_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SCAN,
    CS_POST
  } cid_state_t;

  typedef struct packed {
    logic             clr;
    logic [IDX_W-1:0] rd_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [31:0]      wr_id;
  } cid_req_t;

  typedef struct packed {
    logic [31:0]      rd_id;
    logic             rd_valid;
    logic [CNT_W-1:0] count;
  } cid_rsp_t;

  typedef struct packed {
    cid_status_t      status;
    logic [IDX_W-1:0] slot;
  } cid_res_t;

endpackage

@@ rtl/core/cid_in_if.sv @@
// ----------------------------------------------------------------------------
// cid_in_if - request channel
// Valid/ready channel carrying an opcode and a card id.
// ----------------------------------------------------------------------------
interface cid_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] card_id;

  modport source (output valid, output opcode, output card_id, input ready);
  modport sink   (input valid, input opcode, input card_id, output ready);
endinterface

@@ rtl/core/cid_out_if.sv @@
// ----------------------------------------------------------------------------
// cid_out_if - result channel
// Valid/ready channel carrying status, slot index and valid entry count.
// ----------------------------------------------------------------------------
interface cid_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] slot_index;
  logic [6:0] valid_count;

  modport source (output valid, output status, output slot_index,
                  output valid_count, input ready);
  modport sink   (input valid, input status, input slot_index,
                  input valid_count, output ready);
endinterface

@@ rtl/core/card_id_table.sv @@
// ----------------------------------------------------------------------------
// card_id_table - access card identifier table
// Lookup of the first matching valid slot, insert into the first free slot,
// clear of all marks; every result reports the number of valid entries.
// ----------------------------------------------------------------------------
//
//   channel   dir   beat contents                        handshake
//   in_beat   in    opcode[1:0], card_id[31:0]           valid/ready
//   out_beat  out   status[1:0], slot_index[5:0],        valid/ready
//                   valid_count[6:0]
//
// Lookup and insert walk one slot per cycle through the registered id read
// and one compare unit, stopping at a hit or the last slot; the result waits
// in the post state until the output register takes it. Clear and the unused
// opcode go straight to post. in_beat.ready is high only while the
// sequencer idles, even with the last result still in the output register.
// Reset clears marks and count at once; a stalled output holds the sequencer.
// ----------------------------------------------------------------------------
module card_id_table (
  input  logic clk,
  input  logic rst_n,
  cid_in_if.sink    in_beat,
  cid_out_if.source out_beat
);

  cid_pkg::cid_req_t req;
  cid_pkg::cid_rsp_t rsp;
  cid_pkg::cid_res_t res;
  logic              res_valid;
  logic              res_ready;
  logic              res_take;

  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [1:0] out_status_r;
  logic [5:0] out_slot_r;
  logic [6:0] out_count_r;

  cid_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_beat.valid),
    .in_opcode  (in_beat.opcode),
    .in_card_id (in_beat.card_id),
    .in_ready   (in_beat.ready),
    .rsp        (rsp),
    .req        (req),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  cid_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // advance the result when the output register is empty or being drained
  assign res_ready = !out_valid_r || out_beat.ready;
  assign res_take  = res_valid && res_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_beat.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // count is sampled here, after any insert write or clear has landed
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_status_r <= res.status;
      out_slot_r   <= 6'(res.slot);
      out_count_r  <= 7'(rsp.count);
    end
  end

  assign out_beat.valid       = out_valid_r;
  assign out_beat.status      = out_status_r;
  assign out_beat.slot_index  = out_slot_r;
  assign out_beat.valid_count = out_count_r;

  // a clear empties the table by the next cycle
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat.valid && in_beat.ready && in_beat.opcode == cid_pkg::OP_CLEAR)
    |=> (rsp.count == '0))
    else $error("entry count not zero after clear");

  // count never runs past the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.count <= cid_pkg::CNT_W'(cid_pkg::ENTRIES))
    else $error("entry count exceeds table size");

  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |-> (!out_valid_r || out_beat.ready))
    else $error("result register overwritten while stalled");

  // a request is only taken with no result pending in the sequencer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat.valid && in_beat.ready) |-> (!res_valid && !req.wr_en))
    else $error("request taken while another is in flight");

endmodule

@@ rtl/core/cid_store.sv @@
// ----------------------------------------------------------------------------
// cid_store - id memory, valid marks and entry count
// Single write port, one registered read port; valid marks in flops.
// ----------------------------------------------------------------------------
module cid_store (
  input  logic              clk,
  input  logic              rst_n,
  input  cid_pkg::cid_req_t req,
  output cid_pkg::cid_rsp_t rsp
);

  logic [31:0]                 mem [cid_pkg::ENTRIES];
  logic [cid_pkg::ENTRIES-1:0] valid_r;
  logic [cid_pkg::CNT_W-1:0]   count_r;
  logic [31:0]                 rd_id_r;
  logic                        rd_valid_r;

  // registered read of id and mark
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_idx] <= req.wr_id;
    end
    rd_id_r    <= mem[req.rd_idx];
    rd_valid_r <= valid_r[req.rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (req.clr) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.wr_idx] <= 1'b1;
      count_r             <= count_r + cid_pkg::CNT_W'(1);
    end
  end

  assign rsp.rd_id    = rd_id_r;
  assign rsp.rd_valid = rd_valid_r;
  assign rsp.count    = count_r;

endmodule

@@ rtl/core/cid_scan.sv @@
// ----------------------------------------------------------------------------
// cid_scan - slot scan sequencer
// Walks the slots one per cycle through a single compare unit; finds the
// first matching slot on lookup or the first free slot on insert.
// ----------------------------------------------------------------------------
module cid_scan (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_opcode,
  input  logic [31:0]       in_card_id,
  output logic              in_ready,
  input  cid_pkg::cid_rsp_t rsp,
  output cid_pkg::cid_req_t req,
  output logic              res_valid,
  input  logic              res_ready,
  output cid_pkg::cid_res_t res
);

  cid_pkg::cid_state_t       state_r, state_nxt;
  logic [1:0]                op_r;
  logic [31:0]               id_r;
  logic [cid_pkg::IDX_W-1:0] idx_r;
  logic [cid_pkg::IDX_W-1:0] cmp_idx_r;
  logic                      issue_r;
  logic                      pend_r;
  cid_pkg::cid_res_t         res_r;

  logic accept;
  logic hit;
  logic stop;

  assign accept = in_valid && in_ready;

  // shared compare unit: id match on lookup, free mark on insert
  always_comb begin
    if (op_r == cid_pkg::OP_LOOKUP) begin
      hit = pend_r && rsp.rd_valid && (rsp.rd_id == id_r);
    end else begin
      hit = pend_r && !rsp.rd_valid;
    end
  end

  assign stop = (state_r == cid_pkg::CS_SCAN) && pend_r
                && (hit || (cmp_idx_r == cid_pkg::LAST_IDX));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cid_pkg::CS_IDLE: begin
        if (accept) begin
          if (in_opcode == cid_pkg::OP_LOOKUP || in_opcode == cid_pkg::OP_INSERT) begin
            state_nxt = cid_pkg::CS_SCAN;
          end else begin
            state_nxt = cid_pkg::CS_POST;
          end
        end
      end
      cid_pkg::CS_SCAN: begin
        if (stop) begin
          state_nxt = cid_pkg::CS_POST;
        end
      end
      cid_pkg::CS_POST: begin
        if (res_ready) begin
          state_nxt = cid_pkg::CS_IDLE;
        end
      end
      default: state_nxt = cid_pkg::CS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = (state_r == cid_pkg::CS_IDLE);
    res_valid  = (state_r == cid_pkg::CS_POST);
    res        = res_r;
    req.clr    = accept && (in_opcode == cid_pkg::OP_CLEAR);
    req.rd_idx = idx_r;
    req.wr_en  = stop && hit && (op_r == cid_pkg::OP_INSERT);
    req.wr_idx = cmp_idx_r;
    req.wr_id  = id_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cid_pkg::CS_IDLE;
      issue_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        issue_r <= 1'b1;
        pend_r  <= 1'b0;
      end else if (state_r == cid_pkg::CS_SCAN) begin
        if (stop) begin
          issue_r <= 1'b0;
          pend_r  <= 1'b0;
        end else begin
          pend_r <= issue_r;
          if (issue_r && idx_r == cid_pkg::LAST_IDX) begin
            issue_r <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r         <= in_opcode;
      id_r         <= in_card_id;
      idx_r        <= '0;
      res_r.status <= cid_pkg::ST_OK;
      res_r.slot   <= '0;
    end else if (state_r == cid_pkg::CS_SCAN) begin
      cmp_idx_r <= idx_r;
      if (issue_r && idx_r != cid_pkg::LAST_IDX) begin
        idx_r <= idx_r + cid_pkg::IDX_W'(1);
      end
      if (stop) begin
        if (hit) begin
          res_r.status <= cid_pkg::ST_OK;
          res_r.slot   <= cmp_idx_r;
        end else if (op_r == cid_pkg::OP_LOOKUP) begin
          res_r.status <= cid_pkg::ST_MISS;
          res_r.slot   <= '0;
        end else begin
          res_r.status <= cid_pkg::ST_FULL;
          res_r.slot   <= '0;
        end
      end
    end
  end

endmodule

@@ verif/tb_card_id_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_card_id_table - self-checking bench for the card id table
// A shadow copy of the table predicts status, slot and entry count for every
// request beat. Result beats are checked in order against that prediction.
// Directed cases cover the empty table, duplicates, the unused opcode, clear
// and output back-pressure. Random traffic fills the table to full and mixes
// lookups, inserts, no-ops and clears. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_card_id_table;

  // the fourth opcode is unused and leaves the table alone
  localparam logic [1:0] OP_NOP = 2'd3;

  localparam int HALF_HI      = 6;
  localparam int HALF_LO      = 6;
  localparam int RESET_CYCLES = 8;
  // long enough for a full-table miss plus a margin for stray beats
  localparam int DRAIN_CYCLES = cid_pkg::ENTRIES + 8;
  // long receiver hold-off: the block must stall its input well before this
  localparam int HOLD_CYCLES  = 300;
  // several times the slowest correct run at the 12 ns clock period
  localparam int TIMEOUT_NS   = 5_000_000;

  typedef struct packed {
    cid_pkg::cid_status_t      status;
    logic [cid_pkg::IDX_W-1:0] slot;
    logic [cid_pkg::CNT_W-1:0] count;
  } table_result_t;

  logic clk;
  logic rst_n;

  cid_in_if  in_ch ();
  cid_out_if out_ch ();

  card_id_table u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_ch),
    .out_beat (out_ch)
  );

  // Shadow of the table contents, marks and entry count.
  logic [31:0]   shadow_ids  [cid_pkg::ENTRIES];
  bit            shadow_mark [cid_pkg::ENTRIES];
  int unsigned   shadow_count;

  table_result_t pending_results [$];
  logic [31:0]   id_pool [$];
  int unsigned   fail_count;

  // Random idling on both sides; switched off for the final streaming part.
  bit idle_on;
  // Set by a test to ask the receiver for one long hold-off.
  bit hold_req;

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial clk = 1'b0;

  always begin
    #HALF_LO clk = 1'b1;
    #HALF_HI clk = 1'b0;
  end

  initial begin
    #TIMEOUT_NS;
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction: apply one request to the shadow table and return what the
  // block must answer.
  // --------------------------------------------------------------------------
  function automatic table_result_t predict_table_op(input logic [1:0]  op,
                                                     input logic [31:0] id);
    table_result_t r;
    int            i;
    bit            hit;
    r.status = cid_pkg::ST_OK;
    r.slot   = '0;
    hit      = 1'b0;
    unique case (op)
      cid_pkg::OP_LOOKUP: begin
        // first valid slot in index order whose id matches
        r.status = cid_pkg::ST_MISS;
        for (i = 0; i < cid_pkg::ENTRIES; i++) begin
          if (!hit && shadow_mark[i] && shadow_ids[i] == id) begin
            hit      = 1'b1;
            r.status = cid_pkg::ST_OK;
            r.slot   = cid_pkg::IDX_W'(i);
          end
        end
      end
      cid_pkg::OP_INSERT: begin
        // lowest free slot; duplicates are written again
        r.status = cid_pkg::ST_FULL;
        for (i = 0; i < cid_pkg::ENTRIES; i++) begin
          if (!hit && !shadow_mark[i]) begin
            hit            = 1'b1;
            shadow_ids[i]  = id;
            shadow_mark[i] = 1'b1;
            shadow_count++;
            r.status       = cid_pkg::ST_OK;
            r.slot         = cid_pkg::IDX_W'(i);
          end
        end
      end
      cid_pkg::OP_CLEAR: begin
        for (i = 0; i < cid_pkg::ENTRIES; i++) begin
          shadow_mark[i] = 1'b0;
          shadow_ids[i]  = '0;
        end
        shadow_count = 0;
      end
      default: begin
        // unused opcode: nothing changes
      end
    endcase
    r.count = cid_pkg::CNT_W'(shadow_count);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: offer one request beat and record its prediction once taken.
  // Valid is dropped in the step of acceptance and raised again no earlier
  // than the next edge; the block is busy then anyway.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [1:0] op, input logic [31:0] id);
    int gap;
    @(posedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.card_id <= id;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_table_op(op, id));
    if (op == cid_pkg::OP_INSERT) begin
      id_pool.push_back(id);
      if (id_pool.size() > cid_pkg::ENTRIES) begin
        void'(id_pool.pop_front());
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  // Pick an id: mostly one seen before (or one bit off it) so that lookups
  // hit, otherwise the extremes or a fresh random word.
  function automatic logic [31:0] pick_id();
    logic [31:0] v;
    v = $urandom;
    if (id_pool.size() != 0) begin
      v = id_pool[$urandom_range(0, id_pool.size() - 1)];
    end
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom;
      4:       return v ^ (32'h1 << $urandom_range(0, 31));
      default: return v;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // hold off the results and let the block back up into its input
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 16);
        out_ch.ready <= 1'b0;
        repeat (n - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: compare every result beat with the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    table_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no request outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.slot_index !== want.slot) begin
          $error("slot_index: expected %0d, got %0d", want.slot, out_ch.slot_index);
          fail_count++;
        end
        if (out_ch.valid_count !== want.count) begin
          $error("valid_count: expected %0d, got %0d", want.count, out_ch.valid_count);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Lookups, no-op and clear on a table that has never been written.
  task automatic test_empty_table();
    send_request(cid_pkg::OP_LOOKUP, 32'h0000_0000);
    send_request(cid_pkg::OP_LOOKUP, 32'hFFFF_FFFF);
    send_request(OP_NOP,             32'hFFFF_FFFF);
    send_request(cid_pkg::OP_CLEAR,  32'h0000_0000);
  endtask

  // Extremes of the id, duplicate insert (first slot wins on lookup),
  // misses, the unused opcode, and clear followed by reuse of slot zero.
  task automatic test_insert_and_lookup();
    send_request(cid_pkg::OP_INSERT, 32'h0000_0000);
    send_request(cid_pkg::OP_INSERT, 32'hFFFF_FFFF);
    send_request(cid_pkg::OP_INSERT, 32'h0000_0000);
    send_request(cid_pkg::OP_LOOKUP, 32'h0000_0000);
    send_request(cid_pkg::OP_LOOKUP, 32'hFFFF_FFFF);
    send_request(cid_pkg::OP_LOOKUP, 32'h0000_0001);
    send_request(cid_pkg::OP_LOOKUP, 32'h7FFF_FFFF);
    send_request(OP_NOP,             32'h5555_5555);
    send_request(cid_pkg::OP_INSERT, 32'hAAAA_AAAA);
    send_request(cid_pkg::OP_LOOKUP, 32'hAAAA_AAAA);
    send_request(cid_pkg::OP_CLEAR,  32'hFFFF_FFFF);
    send_request(cid_pkg::OP_LOOKUP, 32'h0000_0000);
    send_request(cid_pkg::OP_INSERT, 32'h8000_0000);
  endtask

  // Hold the receiver off while requests keep coming, so that the output
  // register and the sequencer both fill and the input stalls.
  task automatic test_output_stall();
    hold_req = 1'b1;
    send_request(cid_pkg::OP_INSERT, 32'h1234_5678);
    send_request(cid_pkg::OP_INSERT, 32'h8765_4321);
    send_request(cid_pkg::OP_LOOKUP, 32'h1234_5678);
    send_request(cid_pkg::OP_INSERT, 32'h1234_5678);
    send_request(cid_pkg::OP_LOOKUP, 32'h8765_4321);
    send_request(cid_pkg::OP_CLEAR,  32'h0000_0000);
  endtask

  // Fill from empty to full with lookups mixed in, then push inserts into
  // the full table and look up the last slot before clearing.
  task automatic test_fill_to_full();
    send_request(cid_pkg::OP_CLEAR, $urandom);
    while (shadow_count < cid_pkg::ENTRIES) begin
      if ($urandom_range(0, 4) == 0) begin
        send_request(cid_pkg::OP_LOOKUP, pick_id());
      end else begin
        send_request(cid_pkg::OP_INSERT, pick_id());
      end
    end
    send_request(cid_pkg::OP_INSERT, pick_id());
    send_request(cid_pkg::OP_INSERT, $urandom);
    send_request(cid_pkg::OP_LOOKUP, shadow_ids[cid_pkg::LAST_IDX]);
    send_request(cid_pkg::OP_LOOKUP, $urandom);
    send_request(OP_NOP,             $urandom);
    send_request(cid_pkg::OP_INSERT, pick_id());
    send_request(cid_pkg::OP_CLEAR,  $urandom);
  endtask

  // Mixed random traffic; clears are rare so the table drifts in size.
  task automatic test_random_traffic(input int n);
    int k;
    int w;
    for (k = 0; k < n; k++) begin
      w = $urandom_range(0, 99);
      if (w < 45) begin
        send_request(cid_pkg::OP_LOOKUP, pick_id());
      end else if (w < 82) begin
        send_request(cid_pkg::OP_INSERT, pick_id());
      end else if (w < 96) begin
        send_request(OP_NOP, $urandom);
      end else begin
        send_request(cid_pkg::OP_CLEAR, $urandom);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int i;
    for (i = 0; i < cid_pkg::ENTRIES; i++) begin
      shadow_ids[i]  = '0;
      shadow_mark[i] = 1'b0;
    end
    shadow_count  = 0;
    fail_count    = 0;
    idle_on       = 1'b1;
    hold_req      = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.opcode  = cid_pkg::OP_LOOKUP;
    in_ch.card_id = '0;
    rst_n         = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_insert_and_lookup();
    test_output_stall();
    test_fill_to_full();
    test_random_traffic(150);
    test_fill_to_full();

    // last part: no idling on either side
    idle_on = 1'b0;
    test_random_traffic(60);

    // drain every outstanding result, then watch for stray beats
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
